@@ rtl/core/utf8_to_utf16_truncating_decoder_top_macros.svh @@
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder assertion macros
// Shared concurrent assertion forms; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_TRUNCATING_DECODER_TOP_MACROS_SVH
`define UTF8_TO_UTF16_TRUNCATING_DECODER_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define U8U16_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8u16 assertion failed");
// next-cycle implication
`define U8U16_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8u16 assertion failed");
`else
`define U8U16_ASSERT_NOW(label, clk, rst, ante, cons)
`define U8U16_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/core/u8u16_pkg.sv @@
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types, constants and helpers shared by the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int MAX_BURST = 4;

  localparam logic [15:0] REPL_UNIT  = 16'hFFFD;
  localparam logic [15:0] HI_SURR    = 16'hD800;
  localparam logic [15:0] LO_SURR    = 16'hDC00;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;
  localparam logic [20:0] BMP_MAX    = 21'h0FFFF;

  // All results caused by one input byte.
  typedef struct packed {
    logic [2:0]                 n;
    logic                       done;   // last slot is the done result
    logic [MAX_BURST-1:0][15:0] unit;
    logic [MAX_BURST-1:0][4:0]  count;
  } burst_t;

  function automatic burst_t add_unit(burst_t bu, logic [15:0] u, logic [4:0] c);
    burst_t r;
    r = bu;
    r.unit[bu.n[1:0]]  = u;
    r.count[bu.n[1:0]] = c;
    r.n = bu.n + 3'd1;
    return r;
  endfunction

endpackage

@@ rtl/core/u8u16_front.sv @@
// ----------------------------------------------------------------------------
// u8u16_front
// Accepts UTF-8 bytes, tracks the decode state and builds a result burst.
// ----------------------------------------------------------------------------
module u8u16_front import u8u16_pkg::*; #(
  parameter int MAX_UNITS = 31
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       q_full,
  output logic       in_ready,
  output logic       push,
  output burst_t     burst
);

  localparam int UW = $clog2(MAX_UNITS + 1);
  localparam logic [UW-1:0] CAP      = UW'(MAX_UNITS);
  localparam logic [UW-1:0] CAP_PAIR = UW'(MAX_UNITS - 2);

  logic [20:0]   partial_code, partial_code_next;
  logic [1:0]    bytes_expected, bytes_expected_next;
  logic [1:0]    bytes_held, bytes_held_next;
  logic [UW-1:0] units_emitted, units_emitted_next;
  logic          halted, halted_next;

  logic          accept;
  logic          is_cont;
  logic          stop;
  logic [20:0]   cp;
  logic [20:0]   sup;
  logic [1:0]    held;
  burst_t        bst;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_cont  = (in_byte[7:6] == 2'b10);

  always_comb begin
    bst                 = '0;
    partial_code_next   = partial_code;
    bytes_expected_next = bytes_expected;
    bytes_held_next     = bytes_held;
    units_emitted_next  = units_emitted;
    halted_next         = halted;
    stop                = 1'b0;
    held                = bytes_held;
    cp                  = '0;
    sup                 = '0;

    // flush pending bytes: terminator or bad continuation
    if (!halted && bytes_expected != 2'd0 && (in_byte == 8'd0 || !is_cont)) begin
      partial_code_next   = '0;
      bytes_expected_next = '0;
      bytes_held_next     = '0;
      units_emitted_next  = units_emitted_next + UW'(1);
      bst = add_unit(bst, REPL_UNIT, 5'(units_emitted_next));
      for (int k = 0; k < 2; k++) begin
        if (!stop && 2'(k) < held) begin
          if (units_emitted_next >= CAP) begin
            halted_next = 1'b1;
            stop        = 1'b1;
          end else begin
            units_emitted_next = units_emitted_next + UW'(1);
            bst = add_unit(bst, REPL_UNIT, 5'(units_emitted_next));
          end
        end
      end
    end

    // continuation byte: gather bits, complete the character
    if (in_byte != 8'd0 && !halted && bytes_expected != 2'd0 && is_cont) begin
      partial_code_next   = {partial_code[14:0], in_byte[5:0]};
      bytes_expected_next = bytes_expected - 2'd1;
      bytes_held_next     = bytes_held + 2'd1;
      if (bytes_expected == 2'd1) begin
        cp                  = partial_code_next;
        partial_code_next   = '0;
        bytes_held_next     = '0;
        if (cp <= BMP_MAX) begin
          units_emitted_next = units_emitted_next + UW'(1);
          bst = add_unit(bst, cp[15:0], 5'(units_emitted_next));
        end else if (units_emitted_next > CAP_PAIR) begin
          halted_next = 1'b1;
        end else begin
          // high surrogate keeps all eleven offset bits; the 16-bit sum never overflows
          sup = cp - SUPP_BASE;
          units_emitted_next = units_emitted_next + UW'(1);
          bst = add_unit(bst, HI_SURR + {5'd0, sup[20:10]}, 5'(units_emitted_next));
          units_emitted_next = units_emitted_next + UW'(1);
          bst = add_unit(bst, LO_SURR + {6'd0, sup[9:0]}, 5'(units_emitted_next));
        end
      end
    end

    // lead byte
    if (in_byte != 8'd0 && !halted_next && (bytes_expected == 2'd0 || !is_cont)) begin
      if (units_emitted_next >= CAP) begin
        halted_next = 1'b1;
      end else if (!in_byte[7]) begin
        units_emitted_next = units_emitted_next + UW'(1);
        bst = add_unit(bst, {8'd0, in_byte}, 5'(units_emitted_next));
      end else if (in_byte[7:5] == 3'b110) begin
        partial_code_next   = {16'd0, in_byte[4:0]};
        bytes_expected_next = 2'd1;
      end else if (in_byte[7:4] == 4'b1110) begin
        partial_code_next   = {17'd0, in_byte[3:0]};
        bytes_expected_next = 2'd2;
      end else if (in_byte[7:3] == 5'b11110) begin
        partial_code_next   = {18'd0, in_byte[2:0]};
        bytes_expected_next = 2'd3;
      end else begin
        units_emitted_next = units_emitted_next + UW'(1);
        bst = add_unit(bst, REPL_UNIT, 5'(units_emitted_next));
      end
    end

    // terminator: done result, then start a new name
    if (in_byte == 8'd0) begin
      bst = add_unit(bst, 16'd0, 5'(units_emitted_next));
      bst.done            = 1'b1;
      partial_code_next   = '0;
      bytes_expected_next = '0;
      bytes_held_next     = '0;
      units_emitted_next  = '0;
      halted_next         = 1'b0;
    end
  end

  assign burst = bst;
  assign push  = accept && (bst.n != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_code   <= '0;
      bytes_expected <= '0;
      bytes_held     <= '0;
      units_emitted  <= '0;
      halted         <= 1'b0;
    end else if (accept) begin
      partial_code   <= partial_code_next;
      bytes_expected <= bytes_expected_next;
      bytes_held     <= bytes_held_next;
      units_emitted  <= units_emitted_next;
      halted         <= halted_next;
    end
  end

endmodule

@@ rtl/core/u8u16_queue.sv @@
// ----------------------------------------------------------------------------
// u8u16_queue
// Two-entry burst queue between the decode front and the output back.
// ----------------------------------------------------------------------------
module u8u16_queue import u8u16_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  burst_t push_burst,
  input  logic   pop,
  output logic   full,
  output logic   head_valid,
  output burst_t head
);

  burst_t     slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_burst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/core/u8u16_back.sv @@
// ----------------------------------------------------------------------------
// u8u16_back
// Walks each burst one result per cycle into the output register while out_ready allows.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_truncating_decoder_top_macros.svh"

module u8u16_back import u8u16_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  burst_t      head,
  output logic        pop,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [15:0] out_unit,
  output logic [4:0]  out_count,
  output logic        out_unit_valid,
  output logic        out_done,
  output logic        out_last
);

  burst_t     cur;
  logic       cur_active;
  logic [1:0] idx;
  logic       cur_last;
  logic       load;

  assign cur_last = ({1'b0, idx} + 3'd1 == cur.n);
  assign load     = cur_active && (!out_valid || out_ready);
  assign pop      = head_valid && (!cur_active || (load && cur_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_active <= 1'b0;
      idx        <= '0;
    end else if (pop) begin
      cur_active <= 1'b1;
      idx        <= '0;
    end else if (load && cur_last) begin
      cur_active <= 1'b0;
    end else if (load) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_unit       <= cur.unit[idx];
      out_count      <= cur.count[idx];
      out_last       <= cur_last;
      out_done       <= cur.done && cur_last;
      out_unit_valid <= !(cur.done && cur_last);
    end
  end

  `U8U16_ASSERT_NOW(done_is_last, clk, rst, out_valid && out_done, out_last && !out_unit_valid)
  `U8U16_ASSERT_NEXT(burst_no_gap, clk, rst, out_valid && out_ready && !out_last, out_valid)
  `U8U16_ASSERT_NOW(no_empty_burst, clk, rst, cur_active, cur.n != 3'd0)

endmodule

@@ rtl/core/utf8_to_utf16_truncating_decoder_top.sv @@
// ----------------------------------------------------------------------------
// utf8_to_utf16_truncating_decoder_top
// UTF-8 name bytes in, capped UTF-16 code units and a done result out.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata                               tuser                  tlast
//  s_*      in   [7:0] in_byte                       -                      -
//  m_*      out  [15:0] code_unit, [20:16] count     [0] valid, [1] done    last_of_run
//
// Throughput is one byte per cycle while each byte causes at most one result and
// m_tready stays high. A byte causing k results (up to four) holds the output
// until all k are sent; the two-entry burst queue absorbs that, and s_tready
// drops only when it fills. Bursts pass a queue slot, then the back's cur register.
// rst is synchronous, active high, and returns the decoder to a fresh name.
// Bytes that cause no result (halted, or a lead/continuation in progress)
// never enter the queue.
// ----------------------------------------------------------------------------
module utf8_to_utf16_truncating_decoder_top import u8u16_pkg::*; #(
  parameter int MAX_UNITS = 31
) (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [15:0] code_unit, [20:16] unit_count, [23:21] zero
  output logic [1:0]  m_tuser,   // [0] unit_valid, [1] name_done
  output logic        m_tlast    // last_of_run
);

  logic        q_full;
  logic        push;
  burst_t      push_burst;
  logic        pop;
  logic        head_valid;
  burst_t      head;

  logic [15:0] out_unit;
  logic [4:0]  out_count;
  logic        out_unit_valid;
  logic        out_done;

  // Decode each accepted transaction into a burst of results.
  u8u16_front #(
    .MAX_UNITS (MAX_UNITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_byte  (s_tdata),
    .q_full   (q_full),
    .in_ready (s_tready),
    .push     (push),
    .burst    (push_burst)
  );

  // Hold bursts so the front keeps taking bytes while results drain.
  u8u16_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_burst (push_burst),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // Advance through each burst, one output transaction per cycle while m_tready allows.
  u8u16_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_ready      (m_tready),
    .out_valid      (m_tvalid),
    .out_unit       (out_unit),
    .out_count      (out_count),
    .out_unit_valid (out_unit_valid),
    .out_done       (out_done),
    .out_last       (m_tlast)
  );

  // Pack result fields onto the stream.
  assign m_tdata = {3'd0, out_count, out_unit};
  assign m_tuser = {out_done, out_unit_valid};

endmodule
